// ----- hdl/csr_sparse_matvec_accumulate_core_defines.svh -----
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector core: assertion macros
// Shared assertion wrappers. Defining NO_ASSERTIONS turns every use into
// nothing.
// ----------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATVEC_ACCUMULATE_CORE_DEFINES_SVH
`define CSR_SPARSE_MATVEC_ACCUMULATE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define CSMVA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication, disabled while reset is high.
`define CSMVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CSMVA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CSMVA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/csmva_pkg.sv -----
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector package
// Sizes, field widths, request and status codes, and the control bundle
// shared by the core and its multiply-accumulate unit.
// ----------------------------------------------------------------------------
package csmva_pkg;

   localparam int MAX_ROWS    = 1024;
   localparam int MAX_ENTRIES = 8192;
   localparam int MAX_COLS    = 1024;

   localparam int TYPE_W = 2;
   localparam int POS_W  = 13;
   localparam int COL_W  = 10;
   localparam int PTR_W  = 14;
   localparam int VAL_W  = 32;
   localparam int CNT_W  = 11;
   localparam int STAT_W = 2;

   localparam int ENT_AW = $clog2(MAX_ENTRIES);
   localparam int ROW_AW = $clog2(MAX_ROWS + 1);
   localparam int VEC_AW = $clog2(MAX_COLS);

   // Full product, the rounded product and the row sum over all entries.
   localparam int PROD_W = 2 * VAL_W;
   localparam int RND_W  = PROD_W - 16;
   localparam int ACC_W  = RND_W - 1 + ENT_AW + 1;
   localparam int RES_W  = ACC_W + 1;

   localparam logic [TYPE_W-1:0] REQ_ENTRY     = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ROW_START = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_VECTOR    = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_EVAL      = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_RANGE    = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_POINTERS = 2'd2;

   typedef struct packed {
      logic clear;
      logic mul_en;
   } mac_ctl_type;

endpackage

// ----- hdl/csmva_mac.sv -----
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply-accumulate unit
// One registered Q16.16 product per cycle, rounded to nearest (ties up) and
// summed into a row accumulator wide enough that it can never overflow.
// ----------------------------------------------------------------------------
module csmva_mac
   import csmva_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mac_ctl_type             ctl,
   input  logic signed [VAL_W-1:0] a,
   input  logic signed [VAL_W-1:0] x,
   output logic signed [ACC_W-1:0] acc,
   output logic                    pending
);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     pv_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [RND_W-1:0]  rnd;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= a * x;
      end
   end

   // Rounding adds half an LSB: floor of the shifted product plus bit 15.
   assign rnd    = prod_ff[PROD_W-1:16];
   assign acc_in = acc_ff + ACC_W'(rnd) + ACC_W'({1'b0, prod_ff[15]});

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         pv_ff <= ctl.mul_en;
         if (ctl.clear) begin
            acc_ff <= '0;
         end else if (pv_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign acc     = acc_ff;
   assign pending = pv_ff;

endmodule

// ----- hdl/csr_sparse_matvec_accumulate_core.sv -----
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector accumulate core
// Holds a compressed-sparse-row matrix and a dense vector in on-chip memories
// and updates one result element per evaluate request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and every request
// gives exactly one result, shown for one cycle with rsp_valid; the receiver
// cannot stall, so it must take each result in that cycle. Writes to the
// entry, row-pointer and vector memories, and evaluates of a row outside
// row_count, keep busy low and answer in the next cycle. An evaluate of a
// valid row holds busy while a pointer state checks both row pointers and
// ends the evaluate there when they are inconsistent; otherwise one entry
// a cycle goes through the entry memory read, the vector memory read, the
// multiplier and the accumulator, and the last entry (if any) drains these
// four stages before the result goes out in the same cycle that busy
// falls.
// The memories have no reset and no clearing pass; entries must be written
// before an evaluate reads them. row_count may be written only while idle.
// ----------------------------------------------------------------------------
`include "csr_sparse_matvec_accumulate_core_defines.svh"

module csr_sparse_matvec_accumulate_core
   import csmva_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [TYPE_W-1:0]        req_type,
   input  logic [POS_W-1:0]         req_position,
   input  logic [COL_W-1:0]         req_column,
   input  logic [PTR_W-1:0]         req_row_start,
   input  logic signed [VAL_W-1:0]  req_value,
   input  logic                     req_subtract,
   output logic                     rsp_valid,
   output logic signed [VAL_W-1:0]  rsp_result,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_saturated,
   input  logic                     csr_write_enable,
   input  logic [CNT_W-1:0]         csr_write_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_PTR, ST_RUN} state_type;

   // Memories.
   logic [VAL_W-1:0] val_mem [MAX_ENTRIES];
   logic [COL_W-1:0] col_mem [MAX_ENTRIES];
   logic [PTR_W-1:0] ptr_mem [MAX_ROWS+1];
   logic [VAL_W-1:0] vec_mem [MAX_COLS];

   state_type               state_ff;
   logic [CNT_W-1:0]        row_count_ff;
   logic [PTR_W-1:0]        k_ff;
   logic [PTR_W-1:0]        last_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic                    sub_ff;
   logic                    s1_ff;
   logic                    s2_ff;
   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_result_ff;
   logic [STAT_W-1:0]       rsp_status_ff;
   logic                    rsp_saturated_ff;

   logic [PTR_W-1:0]        ptr_first_ff;
   logic [PTR_W-1:0]        ptr_last_ff;
   logic [VAL_W-1:0]        ent_val_rd_ff;
   logic [COL_W-1:0]        ent_col_rd_ff;
   logic signed [VAL_W-1:0] ent_val_d_ff;
   logic signed [VAL_W-1:0] vec_rd_ff;

   logic                    accept;
   logic                    ent_we;
   logic                    ptr_we;
   logic                    vec_we;
   logic                    write_bad;
   logic                    row_ok;
   logic                    eval_go;
   logic                    issue;
   logic                    drained;
   logic                    ptr_bad;
   logic [ROW_AW-1:0]       ptr_addr;
   logic [ROW_AW-1:0]       ptr_next_addr;

   mac_ctl_type             mac_ctl;
   logic signed [ACC_W-1:0] mac_acc;
   logic                    mac_pending;

   logic signed [RES_W-1:0] fin_res;
   logic                    fin_sat;
   logic signed [VAL_W-1:0] fin_val;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign ent_we = accept && (req_type == REQ_ENTRY) &&
                   (32'(req_position) < MAX_ENTRIES) && (32'(req_column) < MAX_COLS);
   assign ptr_we = accept && (req_type == REQ_ROW_START) && (32'(req_position) <= MAX_ROWS);
   assign vec_we = accept && (req_type == REQ_VECTOR) && (32'(req_position) < MAX_COLS);

   always_comb begin
      case (req_type)
         REQ_ENTRY: begin
            write_bad = (32'(req_position) >= MAX_ENTRIES) || (32'(req_column) >= MAX_COLS);
         end
         REQ_ROW_START: begin
            write_bad = (32'(req_position) > MAX_ROWS);
         end
         REQ_VECTOR: begin
            write_bad = (32'(req_position) >= MAX_COLS);
         end
         default: begin
            write_bad = 1'b0;
         end
      endcase
   end

   assign row_ok  = (32'(req_position) < 32'(row_count_ff)) &&
                    (32'(req_position) < MAX_ROWS);
   assign eval_go = accept && (req_type == REQ_EVAL) && row_ok;

   assign ptr_addr      = req_position[ROW_AW-1:0];
   assign ptr_next_addr = ptr_addr + ROW_AW'(1);

   assign ptr_bad = (ptr_first_ff > ptr_last_ff) || (32'(ptr_last_ff) > MAX_ENTRIES);

   assign issue   = (state_ff == ST_RUN) && (k_ff != last_ff);
   assign drained = !issue && !s1_ff && !s2_ff && !mac_pending;

   // Row-pointer memory: one write port, two read ports for the row bounds.
   always_ff @(posedge clock) begin
      if (ptr_we) begin
         ptr_mem[ptr_addr] <= req_row_start;
      end
      if (eval_go) begin
         ptr_first_ff <= ptr_mem[ptr_addr];
         ptr_last_ff  <= ptr_mem[ptr_next_addr];
      end
   end

   // Entry memory, read once per entry of the row.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         val_mem[req_position[ENT_AW-1:0]] <= req_value;
         col_mem[req_position[ENT_AW-1:0]] <= req_column;
      end
      if (issue) begin
         ent_val_rd_ff <= val_mem[k_ff[ENT_AW-1:0]];
         ent_col_rd_ff <= col_mem[k_ff[ENT_AW-1:0]];
      end
   end

   // Vector memory, addressed by the column just read from the entry memory.
   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[req_position[VEC_AW-1:0]] <= req_value;
      end
      if (s1_ff) begin
         vec_rd_ff    <= vec_mem[ent_col_rd_ff[VEC_AW-1:0]];
         ent_val_d_ff <= ent_val_rd_ff;
      end
   end

   assign mac_ctl.clear  = (state_ff == ST_PTR);
   assign mac_ctl.mul_en = s2_ff;

   csmva_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .a       (ent_val_d_ff),
      .x       (vec_rd_ff),
      .acc     (mac_acc),
      .pending (mac_pending)
   );

   // Combine the old element with the row sum and clamp to 32 bits.
   assign fin_res = sub_ff ? (RES_W'(val_ff) - RES_W'(mac_acc))
                           : (RES_W'(val_ff) + RES_W'(mac_acc));
   assign fin_sat = !((&fin_res[RES_W-1:VAL_W-1]) || !(|fin_res[RES_W-1:VAL_W-1]));
   assign fin_val = !fin_sat ? fin_res[VAL_W-1:0] :
                    fin_res[RES_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                     : {1'b0, {(VAL_W-1){1'b1}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         row_count_ff     <= '0;
         k_ff             <= '0;
         last_ff          <= '0;
         val_ff           <= '0;
         sub_ff           <= 1'b0;
         s1_ff            <= 1'b0;
         s2_ff            <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         rsp_result_ff    <= '0;
         rsp_status_ff    <= STATUS_OK;
         rsp_saturated_ff <= 1'b0;
      end else begin
         // A result goes out for every request except a valid-row evaluate,
         // which answers once its pointers fail or its row has drained.
         rsp_valid_ff <= (accept && !eval_go) || ((state_ff == ST_PTR) && ptr_bad) ||
                         ((state_ff == ST_RUN) && drained);
         s1_ff        <= issue;
         s2_ff        <= s1_ff;
         if (csr_write_enable) begin
            row_count_ff <= csr_write_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_type == REQ_EVAL) begin
                     val_ff <= req_value;
                     sub_ff <= req_subtract;
                     if (row_ok) begin
                        state_ff <= ST_PTR;
                     end else begin
                        rsp_result_ff    <= req_value;
                        rsp_status_ff    <= STATUS_RANGE;
                        rsp_saturated_ff <= 1'b0;
                     end
                  end else begin
                     rsp_result_ff    <= '0;
                     rsp_status_ff    <= write_bad ? STATUS_RANGE : STATUS_OK;
                     rsp_saturated_ff <= 1'b0;
                  end
               end
            end
            ST_PTR: begin
               if (ptr_bad) begin
                  rsp_result_ff    <= val_ff;
                  rsp_status_ff    <= STATUS_POINTERS;
                  rsp_saturated_ff <= 1'b0;
                  state_ff         <= ST_IDLE;
               end else begin
                  k_ff     <= ptr_first_ff;
                  last_ff  <= ptr_last_ff;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (issue) begin
                  k_ff <= k_ff + PTR_W'(1);
               end
               if (drained) begin
                  rsp_result_ff    <= fin_val;
                  rsp_status_ff    <= STATUS_OK;
                  rsp_saturated_ff <= fin_sat;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result    = rsp_result_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // Every transfer leaves the sequencer idle again.
   `CSMVA_ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   // No entry is still in flight once the sequencer is idle.
   `CSMVA_ASSERT_IMPLY(a_idle_pipe_empty, clock, reset, !busy, !s1_ff && !s2_ff && !mac_pending)
   // Reads stay inside the row bounds.
   `CSMVA_ASSERT_IMPLY(a_issue_in_row, clock, reset, issue, k_ff < last_ff)
   // Clamping only happens on a successful evaluate.
   `CSMVA_ASSERT_IMPLY(a_sat_only_ok, clock, reset, rsp_saturated, rsp_status == STATUS_OK)
   // A valid-row evaluate always holds off the next request.
   `CSMVA_ASSERT_NEXT(a_eval_busy, clock, reset, eval_go, busy && !rsp_valid)

endmodule
